[sv/wsfb_pkg.sv]
`default_nettype none

package wsfb_pkg;

  // Item kinds carried in the opcode field of an input item.
  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // Length coding of the second header byte.
  localparam logic [62:0] LEN_SHORT_MAX  = 63'd125;
  localparam logic [62:0] LEN_MEDIUM_MAX = 63'd65535;
  localparam logic [6:0]  CODE_MEDIUM    = 7'd126;
  localparam logic [6:0]  CODE_LONG      = 7'd127;

  // Extended length bytes, key bytes and base bytes in a header.
  localparam logic [3:0] EXT_NONE   = 4'd0;
  localparam logic [3:0] EXT_MEDIUM = 4'd2;
  localparam logic [3:0] EXT_LONG   = 4'd8;
  localparam logic [3:0] KEY_BYTES  = 4'd4;
  localparam logic [3:0] BASE_BYTES = 4'd2;

  // Header bytes go out at index 0 up to 13.
  localparam int HDR_IDX_W = 4;

  typedef struct packed {
    logic        opcode;
    logic        final_fragment;
    logic [3:0]  frame_kind;
    logic        masking_on;
    logic [31:0] mask_key;
    logic [62:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
  } out_item_t;

  // Header byte at the current index and whether it closes the header.
  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       last;
  } hdr_info_t;

endpackage

`default_nettype wire

[sv/wsfb_in_if.sv]
`default_nettype none

interface wsfb_in_if;
  logic                valid;
  logic                ready;
  wsfb_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/wsfb_out_if.sv]
`default_nettype none

interface wsfb_out_if;
  logic                valid;
  logic                ready;
  wsfb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/websocket_frame_builder_unit.sv]
// An item's first result byte goes from the input stage into the output register.
// Throughput: one byte per cycle unless the output stalls; a header item has 2
// to 14 bytes, and the input is stalled while its header goes out.
// The output register holds a finished byte while the next item is taken.
// Reset (synchronous, rst high) empties both stages and closes any open frame.
`default_nettype none

module websocket_frame_builder_unit (
  input  wire logic clk,
  input  wire logic rst,
  wsfb_in_if.sink   items,
  wsfb_out_if.source frame
);

  // Input stage.
  logic                                  s1_valid;
  wsfb_pkg::in_item_t                    s1_item;
  logic [wsfb_pkg::HDR_IDX_W-1:0]        hdr_idx;

  // Frame state.
  logic [62:0] bytes_remaining;
  logic [31:0] key_store;
  logic [1:0]  key_position;
  logic        apply_mask;

  // Output register.
  logic                  out_valid;
  wsfb_pkg::out_item_t   out_data;

  wsfb_pkg::hdr_info_t   hdr;
  wsfb_pkg::out_item_t   result;
  logic                  can_load;
  logic                  is_hdr;
  logic                  drop;
  logic                  emit;
  logic                  s1_done;
  logic [7:0]            key_byte;

  wsfb_hdr_sel u_hdr_sel (
    .item (s1_item),
    .idx  (hdr_idx),
    .info (hdr)
  );

  // Decide what the input stage does this cycle.
  always_comb begin
    can_load = !out_valid || frame.ready;
    is_hdr   = (s1_item.opcode == wsfb_pkg::OP_HEADER);
    drop     = !is_hdr && (bytes_remaining == 63'd0);
    emit     = s1_valid && !drop && can_load;
    s1_done  = s1_valid && (drop || (emit && (!is_hdr || hdr.last)));
    key_byte = apply_mask ? key_store[{~key_position, 3'b000} +: 8] : 8'h00;
  end

  // Form the next result byte.
  always_comb begin
    if (is_hdr) begin
      result.out_byte     = hdr.hdr_byte;
      result.end_of_run   = hdr.last;
      result.end_of_frame = hdr.last && (s1_item.payload_length == 63'd0);
    end else begin
      result.out_byte     = s1_item.data_byte ^ key_byte;
      result.end_of_run   = 1'b1;
      result.end_of_frame = (bytes_remaining == 63'd1);
    end
  end

  assign items.ready = !s1_valid || s1_done;
  assign frame.valid = out_valid;
  assign frame.data  = out_data;

  // Input stage and header byte index.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      hdr_idx  <= '0;
    end else begin
      if (items.ready) begin
        s1_valid <= items.valid;
      end
      if (s1_done) begin
        hdr_idx <= '0;
      end else if (emit && is_hdr) begin
        hdr_idx <= hdr_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item <= items.data;
    end
  end

  // Frame state: a header opens a frame, each emitted payload byte advances it.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      key_store       <= '0;
      key_position    <= '0;
      apply_mask      <= 1'b0;
    end else if (emit) begin
      if (is_hdr) begin
        if (hdr_idx == '0) begin
          bytes_remaining <= s1_item.payload_length;
          key_store       <= s1_item.masking_on ? s1_item.mask_key : 32'd0;
          key_position    <= '0;
          apply_mask      <= s1_item.masking_on;
        end
      end else begin
        bytes_remaining <= bytes_remaining - 63'd1;
        key_position    <= key_position + 2'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[sv/wsfb_hdr_sel.sv]
`default_nettype none

// Selects one byte of the frame header for a registered header item.
module wsfb_hdr_sel (
  input  wire wsfb_pkg::in_item_t                  item,
  input  wire logic [wsfb_pkg::HDR_IDX_W-1:0]      idx,
  output wsfb_pkg::hdr_info_t                      info
);

  logic        is_short;
  logic        is_medium;
  logic [3:0]  ext_n;
  logic [3:0]  total_n;
  logic [6:0]  len_code;
  logic [63:0] len64;
  logic [3:0]  j;
  logic [3:0]  kj;
  logic [2:0]  lsel;
  logic [1:0]  ksel;

  // Classify the payload length and count the header bytes.
  always_comb begin
    is_short  = (item.payload_length <= wsfb_pkg::LEN_SHORT_MAX);
    is_medium = (item.payload_length <= wsfb_pkg::LEN_MEDIUM_MAX);
    if (is_short) begin
      ext_n    = wsfb_pkg::EXT_NONE;
      len_code = item.payload_length[6:0];
    end else if (is_medium) begin
      ext_n    = wsfb_pkg::EXT_MEDIUM;
      len_code = wsfb_pkg::CODE_MEDIUM;
    end else begin
      ext_n    = wsfb_pkg::EXT_LONG;
      len_code = wsfb_pkg::CODE_LONG;
    end
    total_n = wsfb_pkg::BASE_BYTES + ext_n +
              (item.masking_on ? wsfb_pkg::KEY_BYTES : wsfb_pkg::EXT_NONE);
  end

  // Pick the byte: first byte, length byte, extended length, then key.
  always_comb begin
    len64 = {1'b0, item.payload_length};
    j     = idx - wsfb_pkg::BASE_BYTES;
    kj    = j - ext_n;
    lsel  = is_medium ? {2'b00, ~j[0]} : (3'd7 - j[2:0]);
    ksel  = 2'd3 - kj[1:0];
    if (idx == 4'd0) begin
      info.hdr_byte = {item.final_fragment, 3'b000, item.frame_kind};
    end else if (idx == 4'd1) begin
      info.hdr_byte = {item.masking_on, len_code};
    end else if (j < ext_n) begin
      info.hdr_byte = len64[{lsel, 3'b000} +: 8];
    end else begin
      info.hdr_byte = item.mask_key[{ksel, 3'b000} +: 8];
    end
    info.last = (idx == (total_n - 4'd1));
  end

endmodule

`default_nettype wire

[dv/wsfb_frame_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the frame builder, predicts the encoded bytes of
// every accepted item and compares each output transfer with the oldest one.
module wsfb_frame_checker
  import wsfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        pending,
  output int        bytes_checked
);

  // Predicted view of the open frame.
  logic [62:0] open_left;
  logic [31:0] frame_key;
  logic [1:0]  key_idx;
  logic        masked;

  out_item_t expected_bytes[$];
  out_item_t want;

  initial begin
    mismatches    = 0;
    pending       = 0;
    bytes_checked = 0;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("%0t: output byte %0d: %s is %h, expected %h",
             $time, bytes_checked, what, got, exp_val);
    mismatches++;
  endtask

  // Works out the bytes that one accepted item puts on the output.
  task automatic encode_item(input in_item_t it);
    logic [7:0]  hdr [14];
    logic [63:0] wide_len;
    out_item_t   nb;
    int          n;
    n = 0;
    if (it.opcode == OP_HEADER) begin
      wide_len = {1'b0, it.payload_length};
      hdr[n] = {it.final_fragment, 3'b000, it.frame_kind};
      n++;
      if (it.payload_length <= LEN_SHORT_MAX) begin
        hdr[n] = {it.masking_on, it.payload_length[6:0]};
        n++;
      end else if (it.payload_length <= LEN_MEDIUM_MAX) begin
        hdr[n] = {it.masking_on, CODE_MEDIUM};
        n++;
        hdr[n] = wide_len[15:8];
        n++;
        hdr[n] = wide_len[7:0];
        n++;
      end else begin
        hdr[n] = {it.masking_on, CODE_LONG};
        n++;
        for (int k = 7; k >= 0; k--) begin
          hdr[n] = wide_len[8*k +: 8];
          n++;
        end
      end
      // The key goes out most significant byte first.
      if (it.masking_on) begin
        for (int k = 3; k >= 0; k--) begin
          hdr[n] = it.mask_key[8*k +: 8];
          n++;
        end
      end
      open_left = it.payload_length;
      frame_key = it.masking_on ? it.mask_key : 32'h0;
      key_idx   = 2'd0;
      masked    = it.masking_on;
      for (int i = 0; i < n; i++) begin
        nb.out_byte     = hdr[i];
        nb.end_of_run   = (i == n - 1);
        nb.end_of_frame = (i == n - 1) && (it.payload_length == 63'd0);
        expected_bytes.insert(expected_bytes.size(), nb);
      end
    end else if (open_left != 63'd0) begin
      // Payload bytes are masked with the key byte at a rotating position.
      nb.out_byte = it.data_byte;
      if (masked) nb.out_byte = it.data_byte ^ frame_key[8*(3 - key_idx) +: 8];
      key_idx   = key_idx + 2'd1;
      open_left = open_left - 63'd1;
      nb.end_of_run   = 1'b1;
      nb.end_of_frame = (open_left == 63'd0);
      expected_bytes.insert(expected_bytes.size(), nb);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      open_left = '0;
      frame_key = '0;
      key_idx   = '0;
      masked    = 1'b0;
      expected_bytes.delete();
    end else begin
      // Compare an output transfer with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("byte with nothing pending", out_data.out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.end_of_run !== want.end_of_run)
            report_mismatch("end_of_run", 8'(out_data.end_of_run),
                            8'(want.end_of_run));
          if (out_data.end_of_frame !== want.end_of_frame)
            report_mismatch("end_of_frame", 8'(out_data.end_of_frame),
                            8'(want.end_of_frame));
        end
        bytes_checked++;
      end
      if (in_valid && in_ready) encode_item(in_data);
    end
    pending = expected_bytes.size();
  end

endmodule

[dv/websocket_frame_builder_unit_tb.sv]
`timescale 1ns / 100ps

module websocket_frame_builder_unit_tb;
  import wsfb_pkg::*;

  localparam int LONG_HOLD = 64;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   bytes_checked;
  int   items_sent;
  int   headers_sent;
  int   idle_pct;
  bit   hold_req;

  wsfb_in_if  items_if ();
  wsfb_out_if frame_if ();

  websocket_frame_builder_unit uut (
    .clk   (clk),
    .rst   (rst),
    .items (items_if),
    .frame (frame_if)
  );

  wsfb_frame_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (items_if.valid),
    .in_ready      (items_if.ready),
    .in_data       (items_if.data),
    .out_valid     (frame_if.valid),
    .out_ready     (frame_if.ready),
    .out_data      (frame_if.data),
    .mismatches    (mismatches),
    .pending       (pending),
    .bytes_checked (bytes_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    frame_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        frame_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        frame_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 11) - 1;
        frame_if.ready <= 1'b0;
      end else begin
        frame_if.ready <= 1'b1;
      end
    end
  end

  // All fields random; callers override the ones that matter.
  function automatic in_item_t rand_item();
    in_item_t it;
    it.opcode         = 1'($urandom);
    it.final_fragment = 1'($urandom);
    it.frame_kind     = 4'($urandom);
    it.masking_on     = 1'($urandom);
    it.mask_key       = $urandom;
    it.payload_length = 63'({$urandom, $urandom});
    it.data_byte      = 8'($urandom);
    return it;
  endfunction

  // Offers one item, with an optional idle burst first, until it is taken.
  task automatic send_item(input in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic fin, input logic [3:0] kind, input logic mask_on,
                             input logic [31:0] key, input logic [62:0] len);
    in_item_t it;
    it = rand_item();
    it.opcode         = OP_HEADER;
    it.final_fragment = fin;
    it.frame_kind     = kind;
    it.masking_on     = mask_on;
    it.mask_key       = key;
    it.payload_length = len;
    headers_sent++;
    send_item(it);
  endtask

  task automatic send_payload(input logic [7:0] d);
    in_item_t it;
    it = rand_item();
    it.opcode    = OP_PAYLOAD;
    it.data_byte = d;
    send_item(it);
  endtask

  // Random frames: mostly complete short ones, some long frames cut short,
  // and a little noise from stray or missing payload bytes.
  task automatic random_frames(input int budget);
    logic [62:0] len;
    int          npay;
    int          counted;
    int          pick;
    counted = 0;
    while (counted < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len  = 63'($urandom_range(0, 16));
        npay = int'(len);
      end else if (pick < 75) begin
        len  = 63'($urandom_range(17, 125));
        npay = $urandom_range(0, 6);
      end else if (pick < 85) begin
        len  = 63'($urandom_range(126, 65535));
        npay = $urandom_range(0, 6);
      end else begin
        len  = 63'({$urandom, $urandom});
        npay = $urandom_range(0, 6);
      end
      counted += 1 + npay;
      if ($urandom_range(0, 9) == 0) npay += $urandom_range(1, 3);
      else if ($urandom_range(0, 9) == 0 && npay > 0) npay--;
      send_header(1'($urandom), 4'($urandom), $urandom_range(0, 99) < 60, $urandom, len);
      repeat (npay) send_payload(8'($urandom));
    end
  endtask

  initial begin
    int saved_pct;
    int drain;
    items_sent     = 0;
    headers_sent   = 0;
    idle_pct       = 20;
    hold_req       = 1'b0;
    items_if.valid = 1'b0;
    items_if.data  = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: stray payload, empty frames, every length coding at its
    // edges, an abandoned frame and a masked frame that wraps the key.
    send_payload(8'hA5);
    send_header(1'b1, 4'hF, 1'b0, 32'h0000_0000, 63'd0);
    send_header(1'b0, 4'h0, 1'b1, 32'hFFFF_FFFF, 63'd0);
    send_header(1'b1, 4'h1, 1'b1, 32'h0102_0304, 63'd125);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_header(1'b0, 4'h2, 1'b0, 32'h0000_0000, 63'd126);
    send_payload(8'h11);
    send_header(1'b1, 4'h8, 1'b1, 32'h8000_0001, 63'd65535);
    send_header(1'b1, 4'h9, 1'b0, 32'h0000_0000, 63'd65536);
    send_header(1'b0, 4'hA, 1'b1, 32'h7FFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF);
    send_payload(8'h80);
    send_header(1'b1, 4'h1, 1'b1, 32'hA1B2_C3D4, 63'd5);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h5A);
    send_payload(8'hA5);
    send_payload(8'h3C);
    send_payload(8'h42);
    send_header(1'b1, 4'h2, 1'b0, 32'h0000_0000, 63'd1);
    send_payload(8'hFF);

    random_frames(50);

    // Long receiver hold-off while the sender keeps offering a full frame.
    saved_pct = idle_pct;
    idle_pct  = 0;
    hold_req  = 1'b1;
    send_header(1'b1, 4'h2, 1'b1, $urandom, 63'd24);
    repeat (24) send_payload(8'($urandom));
    idle_pct = saved_pct;

    // Sender pauses until the frame has fully drained.
    wait (pending == 0);

    // Alternate idling stretches with calm ones.
    for (int chunk = 0; chunk < 4; chunk++) begin
      idle_pct = (chunk % 2 == 0) ? 30 : 0;
      random_frames(20);
    end

    // Last part at full rate.
    idle_pct = 0;
    random_frames(25);
    items_if.valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);

    $display("Run covered %0d input items (%0d frame headers) and %0d output bytes.",
             items_sent, headers_sent, bytes_checked);
    if (pending != 0)
      $display("%0d predicted output bytes never arrived.", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
